// ----- design/cpr_pkg.sv -----
package cpr_pkg;

  localparam int FRAMES = 16;
  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;
  localparam int FIDX_W = 4;
  localparam int FAULT_W = 32;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

  // Commands broadcast from the sequencer to every frame cell.
  typedef struct packed {
    logic compare;  // latch the lookup match of this cell
    logic home;     // move the hand back to frame 0
    logic step;     // the hand takes one step along the ring
    logic clear;    // end of sequence: empty all frames
  } cell_ctl_t;

endpackage

// ----- design/cpr_cell.sv -----
module cpr_cell #(
  parameter int CELL_IDX  = 0,
  parameter int PAGE_BITS = 20,
  parameter int NW        = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpr_pkg::cell_ctl_t   ctl,
  input  logic                 hit_set,
  input  logic [PAGE_BITS-1:0] key,
  input  logic [NW-1:0]        n_active,
  input  logic                 hand_in,
  output logic                 match_r,
  output logic                 valid_r,
  output logic                 ref_r,
  output logic                 hand_r,
  output logic [PAGE_BITS-1:0] page_r,
  output logic                 beyond,
  output logic                 pass_next,
  output logic                 pass_wrap
);

  localparam logic IS_HOME = (CELL_IDX == 0);

  logic                 active;
  logic                 last_active;
  logic                 match_nxt;
  logic                 valid_nxt;
  logic                 ref_nxt;
  logic                 hand_nxt;
  logic [PAGE_BITS-1:0] page_nxt;

  assign active      = (NW'(CELL_IDX) < n_active);
  assign last_active = (NW'(CELL_IDX + 1) == n_active);
  assign beyond      = hand_r & ~active;
  assign pass_next   = ctl.step & hand_r & ~last_active;
  assign pass_wrap   = ctl.step & hand_r & last_active;

  always_comb begin
    match_nxt = match_r;
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    hand_nxt  = hand_r;
    page_nxt  = page_r;
    if (ctl.compare) begin
      match_nxt = valid_r & active & (page_r == key);
    end
    if (ctl.home) begin
      hand_nxt = IS_HOME;
    end
    if (hit_set) begin
      ref_nxt = 1'b1;
    end
    if (ctl.step) begin
      hand_nxt = hand_in;
      if (hand_r) begin
        if (ref_r) begin
          // Second chance: the bit is taken away and the hand moves on.
          ref_nxt = 1'b0;
        end else begin
          page_nxt  = key;
          valid_nxt = 1'b1;
          ref_nxt   = 1'b1;
        end
      end
    end
    if (ctl.clear) begin
      valid_nxt = 1'b0;
      ref_nxt   = 1'b0;
      hand_nxt  = IS_HOME;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
      hand_r  <= IS_HOME;
    end else begin
      valid_r <= valid_nxt;
      ref_r   <= ref_nxt;
      hand_r  <= hand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r <= match_nxt;
    page_r  <= page_nxt;
  end

endmodule

// ----- design/clock_page_replacement_unit.sv -----
// Channel  | Ports                      | Contents (lowest bit first)
// input    | in_tvalid/tready/tdata     | tdata: page_key; tlast: last_in_sequence
// result   | out_tvalid/tready/tdata    | tdata: frame_index, evicted_page, fault_count
//          |                            | tuser: hit, evicted_valid
// config   | cfg_wr_en, cfg_wr_data     | frames_in_use
//
// A hit goes through these steps from acceptance to result: the word is latched, every
// frame cell compares in parallel, then the lowest match is picked. A miss then walks
// the hand around the ring of cells, one step at a time, at most one step more than
// there are frames in use. One word is in work at a time; a finished result waits in
// the output register while the next word is taken. A hit's result and the last step
// hold while that register is full and stalled. Reset empties all frames at once.
module clock_page_replacement_unit #(
  parameter int PAGE_BITS = 20
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wr_en,
  input  logic [cpr_pkg::CFG_W-1:0]              cfg_wr_data,  // frames_in_use
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((PAGE_BITS+7)/8)*8-1:0]         in_tdata,     // page_key
  input  logic                                   in_tlast,     // last_in_sequence
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // frame_index, evicted_page, fault_count
  output logic [((PAGE_BITS+cpr_pkg::FIDX_W+cpr_pkg::FAULT_W+7)/8)*8-1:0] out_tdata,
  output logic [1:0]                             out_tuser     // hit, evicted_valid
);

  localparam int NW = $clog2(cpr_pkg::FRAMES + 1);
  localparam int CW = (NW > cpr_pkg::CFG_W) ? NW : cpr_pkg::CFG_W;
  localparam int PG_LO = cpr_pkg::FIDX_W;
  localparam int FC_LO = cpr_pkg::FIDX_W + PAGE_BITS;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOK   = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_WALK   = 2'd3;

  logic [1:0]                   state_r, state_nxt;
  logic [cpr_pkg::CFG_W-1:0]    frames_in_use_r;
  logic [PAGE_BITS-1:0]         key_r;
  logic                         last_r;
  logic [cpr_pkg::FAULT_W-1:0]  faults_r, faults_nxt;

  logic                         out_tvalid_r, out_tvalid_nxt;
  logic                         out_hit_r, out_hit_nxt;
  logic                         out_evv_r, out_evv_nxt;
  logic [cpr_pkg::FIDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [PAGE_BITS-1:0]         out_page_r, out_page_nxt;
  logic [cpr_pkg::FAULT_W-1:0]  out_fault_r, out_fault_nxt;

  logic [CW-1:0]                cfg_ext;
  logic [NW-1:0]                n_active;
  cpr_pkg::cell_ctl_t           ctl;
  logic [cpr_pkg::FRAMES-1:0]   hit_set_v;
  logic [cpr_pkg::FRAMES-1:0]   match_v, valid_v, ref_v, hand_v, beyond_v;
  logic [cpr_pkg::FRAMES-1:0]   pass_next_v, pass_wrap_v, hand_in_v;
  logic [cpr_pkg::FRAMES-1:0]   hit_sel;
  logic [PAGE_BITS-1:0]         page_a [cpr_pkg::FRAMES];
  logic [cpr_pkg::FIDX_W-1:0]   hit_idx, hand_idx;
  logic [PAGE_BITS-1:0]         hand_page;
  logic                         hand_valid;
  logic                         out_free;
  logic                         load_out;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_free   = ~out_tvalid_r | out_tready;

  always_comb begin
    out_tdata = '0;
    out_tdata[cpr_pkg::FIDX_W-1:0]          = out_idx_r;
    out_tdata[PG_LO +: PAGE_BITS]           = out_page_r;
    out_tdata[FC_LO +: cpr_pkg::FAULT_W]    = out_fault_r;
  end
  assign out_tuser = {out_evv_r, out_hit_r};

  // A count of zero acts as one frame, and counts past the array are capped.
  always_comb begin
    cfg_ext = CW'(frames_in_use_r);
    if (cfg_ext == '0) begin
      n_active = NW'(1);
    end else if (cfg_ext > CW'(cpr_pkg::FRAMES)) begin
      n_active = NW'(cpr_pkg::FRAMES);
    end else begin
      n_active = NW'(cfg_ext);
    end
  end

  genvar g;
  generate
    for (g = 0; g < cpr_pkg::FRAMES; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign hand_in_v[g] = |pass_wrap_v;
      end else begin : g_rest
        assign hand_in_v[g] = pass_next_v[g-1];
      end
      cpr_cell #(
        .CELL_IDX  (g),
        .PAGE_BITS (PAGE_BITS),
        .NW        (NW)
      ) u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .hit_set   (hit_set_v[g]),
        .key       (key_r),
        .n_active  (n_active),
        .hand_in   (hand_in_v[g]),
        .match_r   (match_v[g]),
        .valid_r   (valid_v[g]),
        .ref_r     (ref_v[g]),
        .hand_r    (hand_v[g]),
        .page_r    (page_a[g]),
        .beyond    (beyond_v[g]),
        .pass_next (pass_next_v[g]),
        .pass_wrap (pass_wrap_v[g])
      );
    end
  endgenerate

  // Lowest set bit of the match vector gives the lowest matching frame.
  assign hit_sel = match_v & (~match_v + {{(cpr_pkg::FRAMES-1){1'b0}}, 1'b1});

  always_comb begin
    hit_idx    = '0;
    hand_idx   = '0;
    hand_page  = '0;
    hand_valid = 1'b0;
    for (int i = 0; i < cpr_pkg::FRAMES; i++) begin
      if (hit_sel[i]) begin
        hit_idx = hit_idx | cpr_pkg::FIDX_W'(i);
      end
      if (hand_v[i]) begin
        hand_idx   = hand_idx | cpr_pkg::FIDX_W'(i);
        hand_page  = hand_page | page_a[i];
        hand_valid = hand_valid | valid_v[i];
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    faults_nxt    = faults_r;
    ctl           = '0;
    hit_set_v     = '0;
    load_out      = 1'b0;
    out_hit_nxt   = out_hit_r;
    out_evv_nxt   = out_evv_r;
    out_idx_nxt   = out_idx_r;
    out_page_nxt  = out_page_r;
    out_fault_nxt = out_fault_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        ctl.compare = 1'b1;
        // After the frame count shrinks, a hand left outside the ring restarts at 0.
        ctl.home    = |beyond_v;
        state_nxt   = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (|match_v) begin
          if (out_free) begin
            hit_set_v     = hit_sel;
            load_out      = 1'b1;
            out_hit_nxt   = 1'b1;
            out_evv_nxt   = 1'b0;
            out_idx_nxt   = hit_idx;
            out_page_nxt  = '0;
            out_fault_nxt = faults_r;
            state_nxt     = ST_IDLE;
          end
        end else begin
          if (faults_r != cpr_pkg::FAULT_MAX) begin
            faults_nxt = faults_r + 1'b1;
          end
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (|(hand_v & ref_v)) begin
          ctl.step = 1'b1;
        end else if (out_free) begin
          ctl.step      = 1'b1;
          load_out      = 1'b1;
          out_hit_nxt   = 1'b0;
          out_evv_nxt   = hand_valid;
          out_idx_nxt   = hand_idx;
          out_page_nxt  = hand_valid ? hand_page : '0;
          out_fault_nxt = faults_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (load_out && last_r) begin
      ctl.clear  = 1'b1;
      faults_nxt = '0;
    end
    out_tvalid_nxt = load_out | (out_tvalid_r & ~out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      frames_in_use_r <= cpr_pkg::CFG_RESET;
      faults_r        <= '0;
      out_tvalid_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      faults_r     <= faults_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        frames_in_use_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      key_r  <= in_tdata[PAGE_BITS-1:0];
      last_r <= in_tlast;
    end
    out_hit_r   <= out_hit_nxt;
    out_evv_r   <= out_evv_nxt;
    out_idx_r   <= out_idx_nxt;
    out_page_r  <= out_page_nxt;
    out_fault_r <= out_fault_nxt;
  end

endmodule

// ----- design/cpr_checker.sv -----
module cpr_checker #(
  parameter int PAGE_BITS = 20
) (
  input logic                                   clk,
  input logic                                   rst_n,
  input logic                                   in_tvalid,
  input logic                                   in_tready,
  input logic                                   out_tvalid,
  input logic                                   out_tready,
  input logic [((PAGE_BITS+cpr_pkg::FIDX_W+cpr_pkg::FAULT_W+7)/8)*8-1:0] out_tdata,
  input logic [1:0]                             out_tuser
);

  localparam int PG_LO = cpr_pkg::FIDX_W;
  localparam int FC_LO = cpr_pkg::FIDX_W + PAGE_BITS;

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // One word is in work at a time: no input is taken right after an acceptance.
  a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on the cycle after an acceptance");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("hit reported together with an eviction");

  a_page_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[PG_LO +: PAGE_BITS] == '0)
    else $error("evicted page not zero without an eviction");

  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[FC_LO +: cpr_pkg::FAULT_W] != '0)
    else $error("miss reported with a zero fault count");

endmodule

bind clock_page_replacement_unit cpr_checker #(.PAGE_BITS(PAGE_BITS)) u_cpr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
